// ===== hw/rtl/hbs_pkg.sv =====
// Shared types and constants for the 3x3 height map smoothing block.
// Used by hbs_ctrl, hbs_datapath and heightmap_box_smooth_3x3.
package hbs_pkg;

  // Default map size limits (top-level parameter defaults)
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  // Field and register widths
  localparam int CFG_DIM_W  = 11;  // map_width / map_height registers
  localparam int HEIGHT_W   = 16;  // max_height, smoothed_height (Q8.8)
  localparam int SAMPLE_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Arithmetic widths
  localparam int SUM_W  = 12;  // up to 9 * 255
  localparam int CNT_W  = 4;   // in-map neighbor count, 1..9
  localparam int NUM_W  = SUM_W + HEIGHT_W;  // sum * max_height
  localparam int DEN_W  = 12;  // 255 * count
  localparam int DVD_W  = NUM_W + 1;         // 2*num + den
  localparam int DVS_W  = DEN_W + 1;         // 2*den
  localparam int QUO_W  = HEIGHT_W;          // quotient never exceeds max_height
  localparam int STEP_W = $clog2(QUO_W);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_HEIGHT = 2'd2;

  // Register reset values
  localparam logic [CFG_DIM_W-1:0] RST_MAP_WIDTH  = 11'd256;
  localparam logic [CFG_DIM_W-1:0] RST_MAP_HEIGHT = 11'd256;
  localparam logic [HEIGHT_W-1:0]  RST_MAX_HEIGHT = 16'd25600;

  // Operation code
  localparam logic OP_DRAIN = 1'b1;

  // Window offset codes: one above/left, center, one below/right
  localparam logic [1:0] WIN_LO  = 2'd0;
  localparam logic [1:0] WIN_MID = 2'd1;
  localparam logic [1:0] WIN_HI  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GATHER,
    ST_FLUSH,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_PUT
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic       accept;    // input beat taken this cycle
    logic       issue;     // read one window byte
    logic [1:0] win_row;
    logic [1:0] win_col;
    logic       mul;       // sum * max_height
    logic       load_div;  // set up divider
    logic       div_step;  // one quotient bit
    logic       put;       // result into output register
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic start_emit;  // current input beat produces a result
  } status_t;

endpackage

// ===== hw/rtl/hbs_ctrl.sv =====
// Sequencer for the 3x3 smoothing block: window gather, multiply, divide, output.
// Depends on hbs_pkg.
module hbs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  output logic              result_valid,
  input  logic              result_stall,
  input  hbs_pkg::status_t  status,
  output hbs_pkg::cmd_t     cmd
);

  hbs_pkg::state_t             state, state_next;
  logic [1:0]                  wrow, wcol;
  logic [hbs_pkg::STEP_W-1:0]  dcnt;
  logic                        out_full;
  logic                        accept;
  logic                        put_ok;
  logic                        win_end;

  assign item_stall = (state != hbs_pkg::ST_IDLE);
  assign accept  = item_valid && !item_stall;
  assign put_ok  = !out_full || !result_stall;
  assign win_end = (wrow == hbs_pkg::WIN_HI) && (wcol == hbs_pkg::WIN_HI);

  always_comb begin
    state_next = state;
    unique case (state)
      hbs_pkg::ST_IDLE:   if (accept && status.start_emit) state_next = hbs_pkg::ST_GATHER;
      hbs_pkg::ST_GATHER: if (win_end) state_next = hbs_pkg::ST_FLUSH;
      hbs_pkg::ST_FLUSH:  state_next = hbs_pkg::ST_MUL;
      hbs_pkg::ST_MUL:    state_next = hbs_pkg::ST_LOAD;
      hbs_pkg::ST_LOAD:   state_next = hbs_pkg::ST_DIV;
      hbs_pkg::ST_DIV:    if (dcnt == hbs_pkg::STEP_W'(hbs_pkg::QUO_W - 1))
                            state_next = hbs_pkg::ST_PUT;
      hbs_pkg::ST_PUT:    if (put_ok) state_next = hbs_pkg::ST_IDLE;
      default:            state_next = hbs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.accept   = accept;
    cmd.win_row  = wrow;
    cmd.win_col  = wcol;
    unique case (state)
      hbs_pkg::ST_GATHER: cmd.issue    = 1'b1;
      hbs_pkg::ST_MUL:    cmd.mul      = 1'b1;
      hbs_pkg::ST_LOAD:   cmd.load_div = 1'b1;
      hbs_pkg::ST_DIV:    cmd.div_step = 1'b1;
      hbs_pkg::ST_PUT:    cmd.put      = put_ok;
      default: ;
    endcase
  end

  assign result_valid = out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= hbs_pkg::ST_IDLE;
      wrow     <= hbs_pkg::WIN_LO;
      wcol     <= hbs_pkg::WIN_LO;
      dcnt     <= '0;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        wrow <= hbs_pkg::WIN_LO;
        wcol <= hbs_pkg::WIN_LO;
      end else if (state == hbs_pkg::ST_GATHER) begin
        if (wcol == hbs_pkg::WIN_HI) begin
          wcol <= hbs_pkg::WIN_LO;
          wrow <= wrow + 2'd1;
        end else begin
          wcol <= wcol + 2'd1;
        end
      end
      if (state == hbs_pkg::ST_LOAD)
        dcnt <= '0;
      else if (state == hbs_pkg::ST_DIV)
        dcnt <= dcnt + 1'b1;
      out_full <= cmd.put || (out_full && result_stall);
    end
  end

endmodule

// ===== hw/rtl/hbs_datapath.sv =====
// Datapath: 4-row ring line store, frame counters, window accumulate,
// scale multiply, restoring divider and output register. Depends on hbs_pkg.
module hbs_datapath #(
  parameter int MAX_WIDTH  = hbs_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = hbs_pkg::DEF_MAX_HEIGHT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [hbs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hbs_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             operation,
  input  logic [hbs_pkg::SAMPLE_W-1:0]     sample,
  output logic [hbs_pkg::HEIGHT_W-1:0]     smoothed_height,
  output logic                             last,
  input  hbs_pkg::cmd_t                    cmd,
  output hbs_pkg::status_t                 status
);

  localparam int CW        = $clog2(MAX_WIDTH);
  localparam int RW        = $clog2(MAX_HEIGHT);
  localparam int AW        = CW + 2;
  localparam int MEM_DEPTH = 4 * (2 ** CW);

  logic [hbs_pkg::CFG_DIM_W-1:0] map_width, map_height;
  logic [hbs_pkg::HEIGHT_W-1:0]  max_height;
  logic [CW-1:0]                 w_m1;
  logic [RW-1:0]                 h_m1;

  logic [RW-1:0] in_row, out_row;
  logic [CW-1:0] in_col, out_col;
  logic          input_done;
  logic          is_sample, ready, restart, is_last;

  logic [hbs_pkg::SAMPLE_W-1:0] mem [MEM_DEPTH];
  logic [hbs_pkg::SAMPLE_W-1:0] rd_data;
  logic [AW-1:0]                wr_addr, rd_addr;
  logic                         wr_en;
  logic                         rd_ok;
  logic                         row_ok, col_ok;
  logic [1:0]                   ring;
  logic [CW-1:0]                col;

  logic [hbs_pkg::SUM_W-1:0] sum;
  logic [hbs_pkg::CNT_W-1:0] cnt;
  logic [hbs_pkg::NUM_W-1:0] num;
  logic [hbs_pkg::DEN_W-1:0] den;
  logic [hbs_pkg::DVD_W-1:0] dividend;
  logic [hbs_pkg::DVS_W-1:0] divisor;
  logic [hbs_pkg::DVS_W-1:0] rem;
  logic [hbs_pkg::QUO_W-1:0] quo;
  logic [hbs_pkg::DVS_W:0]   trial;
  logic                      ge;

  // effective size, clamped to 1..MAX, kept as size minus one
  always_comb begin
    if (map_width == '0)          w_m1 = '0;
    else if (map_width > MAX_WIDTH) w_m1 = CW'(MAX_WIDTH - 1);
    else                          w_m1 = CW'(map_width - 1'b1);
    if (map_height == '0)           h_m1 = '0;
    else if (map_height > MAX_HEIGHT) h_m1 = RW'(MAX_HEIGHT - 1);
    else                            h_m1 = RW'(map_height - 1'b1);
  end

  assign is_sample = (operation != hbs_pkg::OP_DRAIN) && !input_done;
  // point one row and one column back is complete once this sample lands
  assign ready  = (in_row > RW'(1)) || ((in_row == RW'(1)) && (in_col != '0));
  assign status.start_emit = is_sample ? ready : input_done;

  assign is_last = (out_row == h_m1) && (out_col == w_m1);
  assign restart = (cmd.put && is_last) ||
                   (cfg_write && ((cfg_index == hbs_pkg::CFG_MAP_WIDTH) ||
                                  (cfg_index == hbs_pkg::CFG_MAP_HEIGHT)));

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= hbs_pkg::RST_MAP_WIDTH;
      map_height <= hbs_pkg::RST_MAP_HEIGHT;
      max_height <= hbs_pkg::RST_MAX_HEIGHT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        hbs_pkg::CFG_MAP_WIDTH:  map_width  <= cfg_data[hbs_pkg::CFG_DIM_W-1:0];
        hbs_pkg::CFG_MAP_HEIGHT: map_height <= cfg_data[hbs_pkg::CFG_DIM_W-1:0];
        hbs_pkg::CFG_MAX_HEIGHT: max_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame counters
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_row     <= '0;
      in_col     <= '0;
      out_row    <= '0;
      out_col    <= '0;
      input_done <= 1'b0;
    end else begin
      if (cmd.accept && is_sample) begin
        if (in_col == w_m1) begin
          in_col <= '0;
          if (in_row == h_m1) begin
            in_row     <= '0;
            input_done <= 1'b1;
          end else begin
            in_row <= in_row + 1'b1;
          end
        end else begin
          in_col <= in_col + 1'b1;
        end
      end
      if (cmd.put) begin
        if (out_col == w_m1) begin
          out_col <= '0;
          out_row <= out_row + 1'b1;
        end else begin
          out_col <= out_col + 1'b1;
        end
      end
    end
  end

  // window address: ring row and column around the output point
  always_comb begin
    unique case (cmd.win_row)
      hbs_pkg::WIN_LO: begin
        row_ok = (out_row != '0);
        ring   = out_row[1:0] - 2'd1;
      end
      hbs_pkg::WIN_HI: begin
        row_ok = (out_row != h_m1);
        ring   = out_row[1:0] + 2'd1;
      end
      default: begin
        row_ok = 1'b1;
        ring   = out_row[1:0];
      end
    endcase
    unique case (cmd.win_col)
      hbs_pkg::WIN_LO: begin
        col_ok = (out_col != '0);
        col    = out_col - 1'b1;
      end
      hbs_pkg::WIN_HI: begin
        col_ok = (out_col != w_m1);
        col    = out_col + 1'b1;
      end
      default: begin
        col_ok = 1'b1;
        col    = out_col;
      end
    endcase
  end

  assign rd_addr = {ring, col};
  assign wr_addr = {in_row[1:0], in_col};
  assign wr_en   = cmd.accept && is_sample;

  always_ff @(posedge clk) begin
    if (wr_en)
      mem[wr_addr] <= sample;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst)
      rd_ok <= 1'b0;
    else
      rd_ok <= cmd.issue && row_ok && col_ok;
  end

  // accumulate, scale, divide
  assign den      = {cnt, 8'd0} - {8'd0, cnt};  // 255 * count
  assign dividend = {num, 1'b0} + hbs_pkg::DVD_W'(den);
  assign trial    = {rem, quo[hbs_pkg::QUO_W-1]};
  assign ge       = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sum <= '0;
      cnt <= '0;
    end else if (rd_ok) begin
      sum <= sum + hbs_pkg::SUM_W'(rd_data);
      cnt <= cnt + 1'b1;
    end
    if (cmd.mul)
      num <= hbs_pkg::NUM_W'(sum) * hbs_pkg::NUM_W'(max_height);
    if (cmd.load_div) begin
      divisor <= {den, 1'b0};
      rem     <= dividend[hbs_pkg::DVD_W-1:hbs_pkg::QUO_W];
      quo     <= dividend[hbs_pkg::QUO_W-1:0];
    end else if (cmd.div_step) begin
      rem <= ge ? hbs_pkg::DVS_W'(trial - {1'b0, divisor}) : hbs_pkg::DVS_W'(trial);
      quo <= {quo[hbs_pkg::QUO_W-2:0], ge};
    end
    if (cmd.put) begin
      smoothed_height <= quo;
      last            <= is_last;
    end
  end

endmodule

// ===== hw/rtl/heightmap_box_smooth_3x3.sv =====
// heightmap_box_smooth_3x3: streaming border-renormalized 3x3 mean of a height map.
// A beat that yields a result stalls the input until that result is on result_valid;
//   the wait covers nine one-per-cycle window reads and the 16-step divider. Other
//   beats do not stall the input.
// Reset (rst, synchronous, active high) clears the frame counters and restores
//   map_width 256, map_height 256, max_height 25600; the line store is not cleared.
module heightmap_box_smooth_3x3 #(
  parameter int MAX_WIDTH  = hbs_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = hbs_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write port
  input  logic                            cfg_write,
  input  logic [hbs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hbs_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input beats
  input  logic                            item_valid,
  output logic                            item_stall,
  input  logic                            operation,
  input  logic [hbs_pkg::SAMPLE_W-1:0]    sample,
  // result beats
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [hbs_pkg::HEIGHT_W-1:0]    smoothed_height,
  output logic                            last
);

  // Flow per beat that completes a window:
  //   IDLE   accept; the sample is written into the 4-row ring store
  //   GATHER 9 reads of the window, out-of-map neighbors skipped
  //   FLUSH  last read accumulates
  //   MUL    sum * max_height
  //   LOAD   divider set up with (2*num + 255*n) / (2*255*n), rounding half up
  //   DIV    16 quotient bits
  //   PUT    result into the output register once it is free
  // The output register lets the next beat be accepted while a result waits.

  hbs_pkg::cmd_t    cmd;
  hbs_pkg::status_t status;

  hbs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  hbs_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .operation       (operation),
    .sample          (sample),
    .smoothed_height (smoothed_height),
    .last            (last),
    .cmd             (cmd),
    .status          (status)
  );

endmodule
